FILE: rtl/look_at_view_matrix_defines.svh
// Assertion helpers for the view matrix block.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/lavm_pkg.sv
`default_nettype none
package lavm_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 32;
	// width of a normalized magnitude, top bit at M_W-1
	localparam int M_W = 30;
	// cmd bit positions
	localparam int CMD_RIGHT = 0;
	localparam int CMD_LOOK_TO = 1;
endpackage
`default_nettype wire

FILE: rtl/lavm_norm.sv
`default_nettype none
module lavm_norm #(
	parameter int IN_W = 33,
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
	parameter int TAG_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld,
	input  logic signed [IN_W-1:0]           vec_x,
	input  logic signed [IN_W-1:0]           vec_y,
	input  logic signed [IN_W-1:0]           vec_z,
	input  logic [TAG_W-1:0]                 tag,
	output logic                             unit_vld,
	output logic signed [lavm_pkg::VAL_W-1:0] unit_x,
	output logic signed [lavm_pkg::VAL_W-1:0] unit_y,
	output logic signed [lavm_pkg::VAL_W-1:0] unit_z,
	output logic [TAG_W-1:0]                 unit_tag
);
	localparam int M_W = lavm_pkg::M_W;
	localparam int VAL_W = lavm_pkg::VAL_W;
	localparam int GRP = (IN_W + 7) / 8;
	localparam int PAD_W = GRP * 8;
	localparam int PW = $clog2(PAD_W);
	localparam int EXT_W = IN_W + M_W - 1;
	localparam int SQ_W = 2 * M_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RT_W = SUM_W / 2;
	localparam int RM_W = RT_W + 2;
	localparam int DV_W = RT_W + 1;
	localparam int Q_W = FRAC_BITS + 1;

	typedef struct packed {
		logic [TAG_W-1:0]      tag;
		logic [2:0]            neg;
		logic                  zero;
		logic [2:0][M_W-1:0]   m;
	} cy_t;

	// stage 1: magnitudes
	logic                  v_s1;
	logic [2:0][IN_W-1:0]  mag_s1;
	logic [2:0]            neg_s1;
	logic [TAG_W-1:0]      tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1[0] <= vec_x[IN_W-1] ? IN_W'(~vec_x + 1'b1) : IN_W'(vec_x);
		mag_s1[1] <= vec_y[IN_W-1] ? IN_W'(~vec_y + 1'b1) : IN_W'(vec_y);
		mag_s1[2] <= vec_z[IN_W-1] ? IN_W'(~vec_z + 1'b1) : IN_W'(vec_z);
		neg_s1 <= {vec_z[IN_W-1], vec_y[IN_W-1], vec_x[IN_W-1]};
		tag_s1 <= tag;
	end

	// stage 2: leading one inside each byte of the OR of the magnitudes
	logic [PAD_W-1:0]      orv;
	logic [GRP-1:0]        nz_c;
	logic [GRP-1:0][2:0]   lp_c;
	logic                  v_s2;
	logic [GRP-1:0]        nz_s2;
	logic [GRP-1:0][2:0]   lp_s2;
	logic [2:0][IN_W-1:0]  mag_s2;
	logic [2:0]            neg_s2;
	logic [TAG_W-1:0]      tag_s2;

	always_comb begin
		orv = PAD_W'(mag_s1[0] | mag_s1[1] | mag_s1[2]);
		for (int g = 0; g < GRP; g++) begin
			nz_c[g] = |orv[g*8 +: 8];
			lp_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orv[g*8+b]) begin
					lp_c[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		nz_s2 <= nz_c;
		lp_s2 <= lp_c;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		tag_s2 <= tag_s1;
	end

	// stage 3: pick the highest nonzero byte
	logic [PW-1:0]         pos_c;
	logic                  v_s3;
	logic [PW-1:0]         pos_s3;
	logic                  zero_s3;
	logic [2:0][IN_W-1:0]  mag_s3;
	logic [2:0]            neg_s3;
	logic [TAG_W-1:0]      tag_s3;

	always_comb begin
		pos_c = '0;
		for (int g = 0; g < GRP; g++) begin
			if (nz_s2[g]) begin
				pos_c = PW'(g * 8) + PW'(lp_s2[g]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s3 <= pos_c;
		zero_s3 <= ~|nz_s2;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		tag_s3 <= tag_s2;
	end

	// stage 4: shift so the largest magnitude has its top bit at M_W-1;
	// bits shifted out at the bottom are dropped
	logic  v_s4;
	cy_t   cy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cy_s4.m[i] <= M_W'({mag_s3[i], {(M_W-1){1'b0}}} >> pos_s3);
		end
		cy_s4.neg <= neg_s3;
		cy_s4.zero <= zero_s3;
		cy_s4.tag <= tag_s3;
	end

	// stage 5: squares
	logic                  v_s5;
	cy_t                   cy_s5;
	logic [2:0][SQ_W-1:0]  sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= SQ_W'(cy_s4.m[i]) * SQ_W'(cy_s4.m[i]);
		end
		cy_s5 <= cy_s4;
	end

	// square root, one result bit per stage; entry 0 holds the sum
	logic [SUM_W-1:0] sx_x    [0:RT_W];
	logic [RM_W-1:0]  sx_rem  [0:RT_W];
	logic [RT_W-1:0]  sx_root [0:RT_W];
	cy_t              sx_cy   [0:RT_W];
	logic             sx_v    [0:RT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_v[0] <= 1'b0;
		end else begin
			sx_v[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sx_x[0] <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		sx_rem[0] <= '0;
		sx_root[0] <= '0;
		sx_cy[0] <= cy_s5;
	end

	for (genvar k = 1; k <= RT_W; k++) begin : g_sqrt
		logic [RM_W-1:0] rem_sh;
		logic [RM_W-1:0] trial;
		logic            ge;

		always_comb begin
			rem_sh = {sx_rem[k-1][RM_W-3:0], sx_x[k-1][SUM_W-1 -: 2]};
			trial = {sx_root[k-1], 2'b01};
			ge = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sx_v[k] <= 1'b0;
			end else begin
				sx_v[k] <= sx_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sx_rem[k] <= ge ? rem_sh - trial : rem_sh;
			sx_root[k] <= {sx_root[k-1][RT_W-2:0], ge};
			sx_x[k] <= {sx_x[k-1][SUM_W-3:0], 2'b00};
			sx_cy[k] <= sx_cy[k-1];
		end
	end

	// restoring division m << FRAC_BITS / norm, one quotient bit per stage
	logic [2:0][DV_W-1:0] dv_r    [1:Q_W];
	logic [2:0][Q_W-1:0]  dv_q    [1:Q_W];
	logic [RT_W-1:0]      dv_norm [1:Q_W];
	cy_t                  dv_cy   [1:Q_W];
	logic                 dv_v    [1:Q_W];

	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic [2:0][DV_W-1:0] r_in;
		logic [2:0][Q_W-1:0]  q_in;
		logic [RT_W-1:0]      n_in;
		cy_t                  cy_in;
		logic                 v_in;
		logic [2:0][DV_W-1:0] rs;
		logic [2:0]           ge;

		if (j == 1) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					r_in[i] = DV_W'(sx_cy[RT_W].m[i]);
				end
				q_in = '0;
				n_in = sx_root[RT_W];
				cy_in = sx_cy[RT_W];
				v_in = sx_v[RT_W];
			end
		end else begin : g_next
			always_comb begin
				r_in = dv_r[j-1];
				q_in = dv_q[j-1];
				n_in = dv_norm[j-1];
				cy_in = dv_cy[j-1];
				v_in = dv_v[j-1];
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = r_in[i] >= DV_W'(n_in);
				rs[i] = ge[i] ? r_in[i] - DV_W'(n_in) : r_in[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else begin
				dv_v[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_r[j][i] <= {rs[i][DV_W-2:0], 1'b0};
				dv_q[j][i] <= {q_in[i][Q_W-2:0], ge[i]};
			end
			dv_norm[j] <= n_in;
			dv_cy[j] <= cy_in;
		end
	end

	// restore signs; a zero vector gives zero
	logic [2:0][VAL_W-1:0] qe;
	logic [2:0][VAL_W-1:0] res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i] = VAL_W'(dv_q[Q_W][i]);
			if (dv_cy[Q_W].zero) begin
				res_c[i] = '0;
			end else if (dv_cy[Q_W].neg[i]) begin
				res_c[i] = VAL_W'(0) - qe[i];
			end else begin
				res_c[i] = qe[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_vld <= 1'b0;
		end else begin
			unit_vld <= dv_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		unit_x <= res_c[0];
		unit_y <= res_c[1];
		unit_z <= res_c[2];
		unit_tag <= dv_cy[Q_W].tag;
	end
endmodule
`default_nettype wire

FILE: rtl/look_at_view_matrix.sv
`default_nettype none
// Channel   Handshake           Payload
// command   start / busy        cmd, eye_x..z, aim_x..z, up_x..z
// result    strobe (no stall)   row_index, col0..col3, last_row, saturated
//
// Commands are pipelined but paced by busy: a command yields four rows on the
// single result port, and busy stays high after a transfer until gap_q runs out.
// Row 0 delay after the command transfer is set by the two normalizers (at
// Q16.16 by default), each 31 square-root stages plus FRAC_BITS+1 divide
// stages. Rows 1..3 follow back to back.
// Reset clears valid bits and the row sequencer; no state survives a command.
// Nothing stalls: the pipeline advances every cycle, results are not held off.
`include "look_at_view_matrix_defines.svh"
module look_at_view_matrix #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] aim_x,
	input  logic signed [31:0] aim_y,
	input  logic signed [31:0] aim_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               strobe,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               last_row,
	output logic               saturated
);
	localparam int VAL_W = lavm_pkg::VAL_W;
	localparam int DIR_W = VAL_W + 1;
	localparam int WIDE_W = 2 * VAL_W;
	localparam int TAG_W = 6 * VAL_W;

	typedef struct packed {
		logic [VAL_W-1:0] c0;
		logic [VAL_W-1:0] c1;
		logic [VAL_W-1:0] c2;
		logic [VAL_W-1:0] c3;
		logic             sat;
	} row_t;

	// round half away from zero, drop FRAC_BITS fraction bits
	function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] m;
		logic [WIDE_W-1:0] r;
		m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		r = (m + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[WIDE_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// command transfer and pacing
	logic       take;
	logic [1:0] gap_q;

	assign take = start && !busy;
	assign busy = gap_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (take) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// stage a1: view direction at full precision
	logic [2:0][VAL_W-1:0] eye_v, aim_v, up_v;
	logic [2:0][DIR_W-1:0] dir_c;
	logic [DIR_W-1:0]      d_c [0:2];
	logic                  v_a1;
	logic [2:0][DIR_W-1:0] dir_a1;
	logic [2:0][VAL_W-1:0] eye_a1, up_a1;

	always_comb begin
		eye_v = {eye_z, eye_y, eye_x};
		aim_v = {aim_z, aim_y, aim_x};
		up_v = {up_z, up_y, up_x};
		for (int i = 0; i < 3; i++) begin
			if (cmd[lavm_pkg::CMD_LOOK_TO]) begin
				d_c[i] = {aim_v[i][VAL_W-1], aim_v[i]};
			end else begin
				d_c[i] = {aim_v[i][VAL_W-1], aim_v[i]} - {eye_v[i][VAL_W-1], eye_v[i]};
			end
			dir_c[i] = cmd[lavm_pkg::CMD_RIGHT] ? DIR_W'(0) - d_c[i] : d_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a1 <= 1'b0;
		end else begin
			v_a1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		dir_a1 <= dir_c;
		eye_a1 <= eye_v;
		up_a1 <= up_v;
	end

	// forward axis
	logic                  l_vld;
	logic [2:0][VAL_W-1:0] l_unit;
	logic [TAG_W-1:0]      l_tag;

	lavm_norm #(
		.IN_W(DIR_W),
		.FRAC_BITS(FRAC_BITS),
		.TAG_W(TAG_W)
	) u_norm_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.vld(v_a1),
		.vec_x(dir_a1[0]),
		.vec_y(dir_a1[1]),
		.vec_z(dir_a1[2]),
		.tag({eye_a1, up_a1}),
		.unit_vld(l_vld),
		.unit_x(l_unit[0]),
		.unit_y(l_unit[1]),
		.unit_z(l_unit[2]),
		.unit_tag(l_tag)
	);

	logic [2:0][VAL_W-1:0] eye_n1, up_n1;

	assign eye_n1 = l_tag[TAG_W-1 -: 3*VAL_W];
	assign up_n1 = l_tag[3*VAL_W-1:0];

	// stages c1/c2: up x forward
	logic                    v_c1, v_c2;
	logic signed [WIDE_W-1:0] cp_c1 [0:5];
	logic [2:0][VAL_W-1:0]   eye_c1, l_c1, eye_c2, l_c2;
	logic [2:0][WIDE_W-1:0]  rraw_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
		end else begin
			v_c1 <= l_vld;
			v_c2 <= v_c1;
		end
	end

	always_ff @(posedge clk) begin
		cp_c1[0] <= $signed(up_n1[1]) * $signed(l_unit[2]);
		cp_c1[1] <= $signed(up_n1[2]) * $signed(l_unit[1]);
		cp_c1[2] <= $signed(up_n1[2]) * $signed(l_unit[0]);
		cp_c1[3] <= $signed(up_n1[0]) * $signed(l_unit[2]);
		cp_c1[4] <= $signed(up_n1[0]) * $signed(l_unit[1]);
		cp_c1[5] <= $signed(up_n1[1]) * $signed(l_unit[0]);
		eye_c1 <= eye_n1;
		l_c1 <= l_unit;
		for (int i = 0; i < 3; i++) begin
			rraw_c2[i] <= cp_c1[2*i] - cp_c1[2*i+1];
		end
		eye_c2 <= eye_c1;
		l_c2 <= l_c1;
	end

	// right axis
	logic                  r_vld;
	logic [2:0][VAL_W-1:0] r_unit;
	logic [TAG_W-1:0]      r_tag;

	lavm_norm #(
		.IN_W(WIDE_W),
		.FRAC_BITS(FRAC_BITS),
		.TAG_W(TAG_W)
	) u_norm_right (
		.clk(clk),
		.arst_n(arst_n),
		.vld(v_c2),
		.vec_x(rraw_c2[0]),
		.vec_y(rraw_c2[1]),
		.vec_z(rraw_c2[2]),
		.tag({eye_c2, l_c2}),
		.unit_vld(r_vld),
		.unit_x(r_unit[0]),
		.unit_y(r_unit[1]),
		.unit_z(r_unit[2]),
		.unit_tag(r_tag)
	);

	logic [2:0][VAL_W-1:0] eye_n2, l_n2;

	assign eye_n2 = r_tag[TAG_W-1 -: 3*VAL_W];
	assign l_n2 = r_tag[3*VAL_W-1:0];

	// stages x1..x3: forward x right, then rescale
	logic                     v_x1, v_x2, v_x3;
	logic signed [WIDE_W-1:0] up_x1 [0:5];
	logic signed [WIDE_W-1:0] uraw_x2 [0:2];
	logic [2:0][VAL_W-1:0]    eye_x1, l_x1, r_x1, eye_x2, l_x2, r_x2;
	logic [2:0][VAL_W-1:0]    eye_x3, l_x3, r_x3, u_x3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_x1 <= 1'b0;
			v_x2 <= 1'b0;
			v_x3 <= 1'b0;
		end else begin
			v_x1 <= r_vld;
			v_x2 <= v_x1;
			v_x3 <= v_x2;
		end
	end

	always_ff @(posedge clk) begin
		up_x1[0] <= $signed(l_n2[1]) * $signed(r_unit[2]);
		up_x1[1] <= $signed(l_n2[2]) * $signed(r_unit[1]);
		up_x1[2] <= $signed(l_n2[2]) * $signed(r_unit[0]);
		up_x1[3] <= $signed(l_n2[0]) * $signed(r_unit[2]);
		up_x1[4] <= $signed(l_n2[0]) * $signed(r_unit[1]);
		up_x1[5] <= $signed(l_n2[1]) * $signed(r_unit[0]);
		eye_x1 <= eye_n2;
		l_x1 <= l_n2;
		r_x1 <= r_unit;
		for (int i = 0; i < 3; i++) begin
			uraw_x2[i] <= up_x1[2*i] - up_x1[2*i+1];
			u_x3[i] <= VAL_W'(rnd_shift(uraw_x2[i]));
		end
		eye_x2 <= eye_x1;
		l_x2 <= l_x1;
		r_x2 <= r_x1;
		eye_x3 <= eye_x2;
		l_x3 <= l_x2;
		r_x3 <= r_x2;
	end

	// stages d1..d3: translation row, dot products with the negated eye
	logic signed [DIR_W-1:0]     ne_c [0:2];
	logic [2:0][2:0][VAL_W-1:0]  ax_c;
	logic                        v_d1, v_d2, v_d3;
	logic signed [WIDE_W-1:0]    dp_d1 [0:8];
	logic signed [WIDE_W-1:0]    ds_d2 [0:2];
	logic signed [WIDE_W-1:0]    rs_c [0:2];
	logic [2:0][VAL_W-1:0]       t_c;
	logic                        clip_c;
	logic [2:0][VAL_W-1:0]       r_d1, u_d1, l_d1, r_d2, u_d2, l_d2, r_d3, u_d3, l_d3;
	logic [2:0][VAL_W-1:0]       t_d3;
	logic                        clip_d3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ne_c[i] = $signed(DIR_W'(0) - {eye_x3[i][VAL_W-1], eye_x3[i]});
		end
		ax_c[0] = r_x3;
		ax_c[1] = u_x3;
		ax_c[2] = l_x3;
	end

	always_comb begin
		clip_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			rs_c[k] = rnd_shift(ds_d2[k]);
			if (rs_c[k] > 64'sd2147483647) begin
				t_c[k] = {1'b0, {(VAL_W-1){1'b1}}};
				clip_c = 1'b1;
			end else if (rs_c[k] < -64'sd2147483648) begin
				t_c[k] = {1'b1, {(VAL_W-1){1'b0}}};
				clip_c = 1'b1;
			end else begin
				t_c[k] = VAL_W'(rs_c[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
		end else begin
			v_d1 <= v_x3;
			v_d2 <= v_d1;
			v_d3 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				dp_d1[3*k+i] <= $signed(ax_c[k][i]) * ne_c[i];
			end
			ds_d2[k] <= dp_d1[3*k] + dp_d1[3*k+1] + dp_d1[3*k+2];
		end
		r_d1 <= r_x3;
		u_d1 <= u_x3;
		l_d1 <= l_x3;
		r_d2 <= r_d1;
		u_d2 <= u_d1;
		l_d2 <= l_d1;
		r_d3 <= r_d2;
		u_d3 <= u_d2;
		l_d3 <= l_d2;
		t_d3 <= t_c;
		clip_d3 <= clip_c;
	end

	// row sequencer: row 0 goes out at once, rows 1..3 wait in a short shift line
	row_t       row_c [0:3];
	row_t       hold_q [0:2];
	row_t       out_q;
	logic [1:0] left_q;
	logic [1:0] idx_q;
	logic       strobe_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_c[i] = '{c0: r_d3[i], c1: u_d3[i], c2: l_d3[i], c3: '0, sat: 1'b0};
		end
		row_c[3] = '{c0: t_d3[0], c1: t_d3[1], c2: t_d3[2],
			c3: VAL_W'(64'd1 << FRAC_BITS), sat: clip_d3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			left_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (v_d3) begin
			strobe_q <= 1'b1;
			left_q <= 2'd3;
			idx_q <= 2'd0;
		end else if (left_q != 2'd0) begin
			strobe_q <= 1'b1;
			left_q <= left_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end else begin
			strobe_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_d3) begin
			out_q <= row_c[0];
			hold_q[0] <= row_c[1];
			hold_q[1] <= row_c[2];
			hold_q[2] <= row_c[3];
		end else begin
			// advance the line one row per cycle
			out_q <= hold_q[0];
			hold_q[0] <= hold_q[1];
			hold_q[1] <= hold_q[2];
		end
	end

	assign strobe = strobe_q;
	assign row_index = idx_q;
	assign col0 = out_q.c0;
	assign col1 = out_q.c1;
	assign col2 = out_q.c2;
	assign col3 = out_q.c3;
	assign last_row = idx_q == 2'd3;
	assign saturated = out_q.sat;

	// a transfer always blocks the next cycle
	`LAVM_ASSERT_NEXT(a_busy_after_take, start && !busy, busy, "busy not raised after a transfer")
	// rows of one matrix come back to back in order
	`LAVM_ASSERT_NEXT(a_row_burst, strobe && row_index != 2'd3, strobe && row_index == 2'($past(row_index) + 2'd1), "row burst broken")
	// rotation rows never clip and end in zero
	`LAVM_ASSERT_NOW(a_rot_rows, strobe && !last_row, !saturated && col3 == '0, "bad rotation row")
endmodule
`default_nettype wire
